// ===== rtl/core/qou_pkg.sv =====
// Shared types, constants and helpers for the quaternion orientation unit.
// No dependencies.
`timescale 1ns / 1ps
package qou_pkg;

    localparam int FRAC_BITS_DEF = 14;

    typedef enum logic [1:0] {
        ACT_COMPOSE = 2'd0,
        ACT_LOAD    = 2'd1,
        ACT_CONJ    = 2'd2,
        ACT_HOLD    = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]  action;
        logic signed [15:0] in_w;
        logic signed [15:0] in_x;
        logic signed [15:0] in_y;
        logic signed [15:0] in_z;
        logic        renormalize;
    } qou_in_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } qou_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_SUMSQ,
        ST_SQRT,
        ST_DIV,
        ST_MAT,
        ST_OUT
    } qou_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic step;
        logic update;
        logic sq_start;
        logic sqrt_start;
        logic div_start;
        logic mat_start;
        logic out_load;
    } qou_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic step_last;
        logic sqrt_done;
        logic div_done;
        logic zero_mag;
        logic norm_req;
    } qou_sts_t;

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767)       return 16'sh7fff;
        else if (v < -64'sd32768) return 16'sh8000;
        else                      return v[15:0];
    endfunction

endpackage

// ===== rtl/core/qou_ctrl.sv =====
// Controller state machine of the quaternion orientation unit.
// Depends on qou_pkg.
`timescale 1ns / 1ps
module qou_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  qou_pkg::qou_sts_t sts,
    output qou_pkg::qou_cmd_t cmd
);

    qou_pkg::qou_state_t state_reg, state_next;
    logic                m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= qou_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            qou_pkg::ST_IDLE:  if (s_valid) state_next = qou_pkg::ST_MUL;
            qou_pkg::ST_MUL:   if (sts.step_last) state_next = qou_pkg::ST_UPD;
            qou_pkg::ST_UPD:
                state_next = sts.norm_req ? qou_pkg::ST_SUMSQ : qou_pkg::ST_MAT;
            qou_pkg::ST_SUMSQ: if (sts.step_last) state_next = qou_pkg::ST_SQRT;
            qou_pkg::ST_SQRT:
                if (sts.zero_mag) state_next = qou_pkg::ST_MAT;
                else if (sts.sqrt_done) state_next = qou_pkg::ST_DIV;
            qou_pkg::ST_DIV:   if (sts.div_done) state_next = qou_pkg::ST_MAT;
            qou_pkg::ST_MAT:   if (sts.step_last) state_next = qou_pkg::ST_OUT;
            qou_pkg::ST_OUT:   if (!m_valid_reg || m_ready) state_next = qou_pkg::ST_IDLE;
            default:           state_next = qou_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            qou_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            qou_pkg::ST_MUL:   cmd.step = 1'b1;
            qou_pkg::ST_UPD: begin
                cmd.update   = 1'b1;
                cmd.sq_start = sts.norm_req;
                cmd.mat_start = !sts.norm_req;
            end
            qou_pkg::ST_SUMSQ: begin
                cmd.step       = 1'b1;
                cmd.sqrt_start = sts.step_last;
            end
            qou_pkg::ST_SQRT: begin
                cmd.div_start = sts.sqrt_done && !sts.zero_mag;
                cmd.mat_start = sts.zero_mag;
            end
            qou_pkg::ST_DIV:   cmd.mat_start = sts.div_done;
            qou_pkg::ST_MAT:   cmd.step = 1'b1;
            qou_pkg::ST_OUT:
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/core/qou_datapath.sv =====
// Datapath: state quaternion, shared multiplier, square root and divider.
// Depends on qou_pkg.
`timescale 1ns / 1ps
module qou_datapath #(
    parameter int FRAC_BITS = qou_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  qou_pkg::qou_in_t  s_item,
    input  qou_pkg::qou_cmd_t cmd,
    output qou_pkg::qou_sts_t sts,
    output qou_pkg::qou_out_t m_item
);

    localparam logic signed [63:0] ONE_Q  = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] ONE2_Q = 64'sd1 <<< (2 * FRAC_BITS);
    localparam logic signed [63:0] HALF_Q = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [15:0] ONE16  =
        (ONE_Q > 64'sd32767) ? 16'sh7fff : ONE_Q[15:0];
    localparam int DSH = FRAC_BITS + 8;
    localparam int DNW = 16 + DSH;

    logic signed [15:0] q_reg [4];
    logic signed [15:0] a_reg [4];
    logic [1:0]         act_reg;
    logic               norm_reg;
    logic [3:0]         cnt_reg;
    // phase: 0 compose, 1 sum of squares, 2 matrix
    logic [1:0]         phase_reg;
    logic signed [37:0] acc_reg [9];
    logic signed [37:0] ssum_reg;
    logic signed [37:0] ssum_next;

    // shared 16x16 multiplier, one product per cycle, accumulated the same cycle
    logic signed [15:0] op_a, op_b;
    logic [3:0]         tgt;
    logic               neg;
    logic signed [15:0] mx_a, mx_b;
    logic signed [15:0] sel_a, sel_b;
    logic signed [31:0] sel_p;
    logic signed [37:0] pterm;
    logic [3:0]         last_cnt;

    // square root of s * 2^16, two radicand bits per cycle
    logic [53:0] rad_reg;
    logic [27:0] root_reg;
    logic [29:0] rem_reg;
    logic [4:0]  scnt_reg;
    logic        sbusy_reg;
    logic        zero_now;
    logic [29:0] trial;
    logic [29:0] rem_sh;

    // restoring divider, one quotient bit per cycle, four components in turn
    logic [1:0]       div_idx_reg;
    logic             dbusy_reg;
    logic [5:0]       dcnt_reg;
    logic [DNW-1:0]   dnum_reg;
    logic [DNW-1:0]   dquo_reg;
    logic [28:0]      drem_reg;
    logic             dneg_reg;
    logic             div_wr;
    logic signed [15:0] div_res;
    logic [28:0]      drem_sh;
    logic [15:0]      absv;
    logic [DNW-1:0]   num0;
    logic             dfirst_reg;

    logic signed [63:0] mraw [9];
    qou_pkg::qou_out_t  out_reg;

    // compose schedule: 16 products
    always_comb begin
        op_a = '0; op_b = '0; tgt = '0; neg = 1'b0;
        case (cnt_reg)
            4'd0:  begin op_a = q_reg[0]; op_b = a_reg[0]; tgt = 4'd0; end
            4'd1:  begin op_a = q_reg[1]; op_b = a_reg[1]; tgt = 4'd0; neg = 1'b1; end
            4'd2:  begin op_a = q_reg[2]; op_b = a_reg[2]; tgt = 4'd0; neg = 1'b1; end
            4'd3:  begin op_a = q_reg[3]; op_b = a_reg[3]; tgt = 4'd0; neg = 1'b1; end
            4'd4:  begin op_a = q_reg[0]; op_b = a_reg[1]; tgt = 4'd1; end
            4'd5:  begin op_a = q_reg[1]; op_b = a_reg[0]; tgt = 4'd1; end
            4'd6:  begin op_a = q_reg[3]; op_b = a_reg[2]; tgt = 4'd1; end
            4'd7:  begin op_a = q_reg[2]; op_b = a_reg[3]; tgt = 4'd1; neg = 1'b1; end
            4'd8:  begin op_a = q_reg[0]; op_b = a_reg[2]; tgt = 4'd2; end
            4'd9:  begin op_a = q_reg[2]; op_b = a_reg[0]; tgt = 4'd2; end
            4'd10: begin op_a = q_reg[1]; op_b = a_reg[3]; tgt = 4'd2; end
            4'd11: begin op_a = q_reg[3]; op_b = a_reg[1]; tgt = 4'd2; neg = 1'b1; end
            4'd12: begin op_a = q_reg[0]; op_b = a_reg[3]; tgt = 4'd3; end
            4'd13: begin op_a = q_reg[3]; op_b = a_reg[0]; tgt = 4'd3; end
            4'd14: begin op_a = q_reg[2]; op_b = a_reg[1]; tgt = 4'd3; end
            default: begin op_a = q_reg[1]; op_b = a_reg[2]; tgt = 4'd3; neg = 1'b1; end
        endcase
    end

    // matrix products: the Kth product lands in accumulator K
    // product list: yy zz xx xy zw zx yw yz xw (9)
    always_comb begin
        mx_a = '0; mx_b = '0;
        case (cnt_reg)
            4'd0: begin mx_a = q_reg[2]; mx_b = q_reg[2]; end
            4'd1: begin mx_a = q_reg[3]; mx_b = q_reg[3]; end
            4'd2: begin mx_a = q_reg[1]; mx_b = q_reg[1]; end
            4'd3: begin mx_a = q_reg[1]; mx_b = q_reg[2]; end
            4'd4: begin mx_a = q_reg[3]; mx_b = q_reg[0]; end
            4'd5: begin mx_a = q_reg[3]; mx_b = q_reg[1]; end
            4'd6: begin mx_a = q_reg[2]; mx_b = q_reg[0]; end
            4'd7: begin mx_a = q_reg[2]; mx_b = q_reg[3]; end
            default: begin mx_a = q_reg[1]; mx_b = q_reg[0]; end
        endcase
    end

    always_comb begin
        case (phase_reg)
            2'd0:    begin sel_a = op_a; sel_b = op_b; end
            2'd1:    begin sel_a = q_reg[cnt_reg[1:0]]; sel_b = q_reg[cnt_reg[1:0]]; end
            default: begin sel_a = mx_a; sel_b = mx_b; end
        endcase
    end
    assign sel_p = sel_a * sel_b;

    always_comb begin
        case (phase_reg)
            2'd0:    last_cnt = 4'd15;
            2'd1:    last_cnt = 4'd3;
            default: last_cnt = 4'd8;
        endcase
    end
    assign sts.step_last = cmd.step && (cnt_reg == last_cnt);

    // only the compose schedule subtracts
    assign pterm = ((phase_reg == 2'd0) && neg) ? -38'(sel_p) : 38'(sel_p);
    assign ssum_next = ssum_reg + 38'(sel_p);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg[0]  <= ONE16;
            q_reg[1]  <= '0;
            q_reg[2]  <= '0;
            q_reg[3]  <= '0;
            cnt_reg   <= '0;
            phase_reg <= 2'd0;
        end else begin
            if (cmd.load_item) begin
                a_reg[0] <= s_item.in_w;
                a_reg[1] <= s_item.in_x;
                a_reg[2] <= s_item.in_y;
                a_reg[3] <= s_item.in_z;
                act_reg  <= s_item.action;
                norm_reg <= s_item.renormalize;
                cnt_reg  <= '0;
                phase_reg <= 2'd0;
                for (int i = 0; i < 4; i++) acc_reg[i] <= '0;
            end
            if (cmd.step) begin
                cnt_reg <= (cnt_reg == last_cnt) ? 4'd0 : cnt_reg + 4'd1;
                case (phase_reg)
                    2'd0:    acc_reg[tgt] <= acc_reg[tgt] + pterm;
                    2'd1:    ssum_reg <= ssum_next;
                    default: acc_reg[cnt_reg] <= acc_reg[cnt_reg] + pterm;
                endcase
            end
            if (cmd.sq_start) begin
                phase_reg <= 2'd1;
                ssum_reg  <= '0;
            end
            if (cmd.mat_start) begin
                phase_reg <= 2'd2;
                for (int i = 0; i < 9; i++) acc_reg[i] <= '0;
            end
            if (cmd.update) begin
                case (act_reg)
                    qou_pkg::ACT_COMPOSE:
                        for (int i = 0; i < 4; i++)
                            q_reg[i] <= qou_pkg::sat16(
                                (64'(acc_reg[i]) + HALF_Q) >>> FRAC_BITS);
                    qou_pkg::ACT_LOAD:
                        for (int i = 0; i < 4; i++) q_reg[i] <= a_reg[i];
                    qou_pkg::ACT_CONJ:
                        for (int i = 1; i < 4; i++)
                            q_reg[i] <= qou_pkg::sat16(-64'(q_reg[i]));
                    default: ;
                endcase
            end
            if (zero_now) begin
                q_reg[0] <= ONE16;
                q_reg[1] <= '0;
                q_reg[2] <= '0;
                q_reg[3] <= '0;
            end
            if (div_wr) q_reg[div_idx_reg] <= div_res;
        end
    end

    // the compose products run for every action and update picks what it
    // needs, so the sequence length stays fixed
    assign sts.norm_req = norm_reg;

    // zero magnitude: skip the divides and drop to the identity
    assign zero_now = cmd.mat_start && (phase_reg == 2'd1) && sts.zero_mag;
    assign sts.zero_mag = (ssum_reg == '0);

    assign rem_sh = {rem_reg[27:0], rad_reg[53:52]};
    assign trial  = {root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sbusy_reg <= 1'b0;
        end else if (cmd.sqrt_start) begin
            sbusy_reg <= 1'b1;
            scnt_reg  <= '0;
            rad_reg   <= {ssum_next, 16'd0};
            root_reg  <= '0;
            rem_reg   <= '0;
        end else if (sbusy_reg) begin
            rad_reg <= {rad_reg[51:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[26:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[26:0], 1'b0};
            end
            scnt_reg <= scnt_reg + 5'd1;
            if (scnt_reg == 5'd26) sbusy_reg <= 1'b0;
        end
    end
    assign sts.sqrt_done = !sbusy_reg && !cmd.sqrt_start && (scnt_reg == 5'd27);

    assign absv = q_reg[div_idx_reg][15] ? 16'(-q_reg[div_idx_reg]) : q_reg[div_idx_reg];
    assign num0 = (DNW'(absv) << DSH) + DNW'(root_reg[27:1]);
    assign drem_sh = {drem_reg[27:0], dnum_reg[DNW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            div_wr    <= 1'b0;
        end else begin
            div_wr <= 1'b0;
            if (cmd.div_start) begin
                dbusy_reg   <= 1'b1;
                div_idx_reg <= '0;
                dfirst_reg  <= 1'b1;
            end else if (dbusy_reg && dfirst_reg) begin
                dnum_reg   <= num0;
                dneg_reg   <= q_reg[div_idx_reg][15];
                drem_reg   <= '0;
                dquo_reg   <= '0;
                dcnt_reg   <= '0;
                dfirst_reg <= 1'b0;
            end else if (dbusy_reg && !div_wr) begin
                dnum_reg <= {dnum_reg[DNW-2:0], 1'b0};
                if ({1'b0, drem_sh} >= {2'b0, root_reg}) begin
                    drem_reg <= drem_sh - 29'(root_reg);
                    dquo_reg <= {dquo_reg[DNW-2:0], 1'b1};
                end else begin
                    drem_reg <= drem_sh;
                    dquo_reg <= {dquo_reg[DNW-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 6'd1;
                if (dcnt_reg == 6'(DNW - 1)) div_wr <= 1'b1;
            end else if (div_wr) begin
                dfirst_reg <= 1'b1;
                if (div_idx_reg == 2'd3) dbusy_reg <= 1'b0;
                else div_idx_reg <= div_idx_reg + 2'd1;
            end
        end
    end
    assign div_res = qou_pkg::sat16(dneg_reg ? -64'(dquo_reg) : 64'(dquo_reg));
    assign sts.div_done = div_wr && (div_idx_reg == 2'd3);

    // matrix entries from accumulated products: acc index = product number
    always_comb begin
        mraw[0] = ONE2_Q - 2 * (64'(acc_reg[0]) + 64'(acc_reg[1]));
        mraw[1] = 2 * (64'(acc_reg[3]) - 64'(acc_reg[4]));
        mraw[2] = 2 * (64'(acc_reg[5]) + 64'(acc_reg[6]));
        mraw[3] = 2 * (64'(acc_reg[3]) + 64'(acc_reg[4]));
        mraw[4] = ONE2_Q - 2 * (64'(acc_reg[1]) + 64'(acc_reg[2]));
        mraw[5] = 2 * (64'(acc_reg[7]) - 64'(acc_reg[8]));
        mraw[6] = 2 * (64'(acc_reg[5]) - 64'(acc_reg[6]));
        mraw[7] = 2 * (64'(acc_reg[7]) + 64'(acc_reg[8]));
        mraw[8] = ONE2_Q - 2 * (64'(acc_reg[0]) + 64'(acc_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.m00 <= qou_pkg::sat16((mraw[0] + HALF_Q) >>> FRAC_BITS);
            out_reg.m01 <= qou_pkg::sat16((mraw[1] + HALF_Q) >>> FRAC_BITS);
            out_reg.m02 <= qou_pkg::sat16((mraw[2] + HALF_Q) >>> FRAC_BITS);
            out_reg.m10 <= qou_pkg::sat16((mraw[3] + HALF_Q) >>> FRAC_BITS);
            out_reg.m11 <= qou_pkg::sat16((mraw[4] + HALF_Q) >>> FRAC_BITS);
            out_reg.m12 <= qou_pkg::sat16((mraw[5] + HALF_Q) >>> FRAC_BITS);
            out_reg.m20 <= qou_pkg::sat16((mraw[6] + HALF_Q) >>> FRAC_BITS);
            out_reg.m21 <= qou_pkg::sat16((mraw[7] + HALF_Q) >>> FRAC_BITS);
            out_reg.m22 <= qou_pkg::sat16((mraw[8] + HALF_Q) >>> FRAC_BITS);
        end
    end
    assign m_item = out_reg;

endmodule

// ===== rtl/core/quaternion_orientation_unit.sv =====
// Quaternion orientation unit: compose/load/conjugate, renormalise, rotation matrix.
// With renormalise the result also waits for a square root and four divides; a zero
// magnitude skips both and gives the identity.
// Throughput: one item at a time, the next item is taken once the result is registered;
// an unaccepted result holds the next one back.
// Reset (aresetn, synchronous, active low): state to the identity, no item pending.
`timescale 1ns / 1ps
module quaternion_orientation_unit #(
    parameter int FRAC_BITS = qou_pkg::FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  qou_pkg::qou_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output qou_pkg::qou_out_t m_item
);

    qou_pkg::qou_cmd_t cmd;
    qou_pkg::qou_sts_t sts;

    qou_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .sts, .cmd
    );

    qou_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk, .aresetn, .s_item, .cmd, .sts, .m_item
    );

`ifndef NO_ASSERTIONS
    a_no_take_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_item, cmd.out_load})) else $error("load and output clash");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("second item taken");
`endif

endmodule
